[sv/prdr_pkg.sv]
`timescale 1ns / 1ps

package prdr_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

	localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
	localparam int LINE_WIDTH_RST   = 1024;
	localparam int FRAME_HEIGHT_RST = 768;

	localparam logic [31:0] ALPHA_BITS = 32'hFF00_0000;

	localparam logic [5:0] RED_POS   = 6'd8;
	localparam logic [5:0] GREEN_POS = 6'd16;
	localparam logic [5:0] BLUE_POS  = 6'd24;

	typedef struct packed {
		logic frame_start;
		logic row_end;
		logic frame_end;
	} prdr_flags_t;

	typedef struct packed {
		logic       left;
		logic [4:0] amt;
	} prdr_shift_t;

	function automatic logic [5:0] bit_len(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 6'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic prdr_shift_t shift_of(input logic [31:0] mask, input logic [5:0] pos);
		logic [5:0] len;
		prdr_shift_t s;
		len = bit_len(mask);
		if (len > pos) begin
			s.left = 1'b0;
			s.amt  = 5'(len - pos);
		end else begin
			s.left = 1'b1;
			s.amt  = 5'(pos - len);
		end
		return s;
	endfunction

	function automatic logic [31:0] place(input logic [31:0] bits, input prdr_shift_t s);
		logic [31:0] r;
		if (s.left) begin
			r = bits << s.amt;
		end else begin
			r = bits >> s.amt;
		end
		return r;
	endfunction

endpackage

[sv/pixel_repack_dirty_rows.sv]
`timescale 1ns / 1ps
// pixel repacker with dirty-row detection
// pixel channel: one raw 32-bit pixel per transaction (pixel_valid, pixel_stall), raster
//   order, frame_start on the first pixel of each frame
// result channel: a texel result (kind 0) for every pixel, followed by a dirty span
//   result (kind 1) when the pixel closes a run of changed rows; last marks the final
//   result of a pixel
// cfg channel: cfg_index selects red, green, blue mask, line width, frame height;
//   cfg_ready is always high, write only while no pixel is in flight
// throughput: one pixel per cycle while the receiver does not stall; a pixel that
//   closes a span also puts a span result into the result register, so that
//   register (one result per cycle) sets the rate, with at most one frame store
//   read and one write each cycle
// a four-entry queue sits between the classifying front and the compare back end;
//   when the receiver stalls, the queue fills and then pixel_stall rises
// reset: registers take their default values, counters go to zero and the first
//   complete frame is reported dirty; the frame store is not cleared
module pixel_repack_dirty_rows
	import prdr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [31:0]          pixel_word,
	input  logic                 frame_start,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 kind,
	output logic [31:0]          texel,
	output logic [9:0]           span_first_row,
	output logic [10:0]          span_rows,
	output logic                 last
);

	localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW      = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
	localparam int FW      = $bits(prdr_flags_t);
	localparam int QW      = 32 + AW + RW + FW;
	localparam int Q_DEPTH = 4;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [31:0]   f_texel;
	logic [AW-1:0] f_addr;
	logic [RW-1:0] f_row;
	prdr_flags_t   f_flags;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	logic [31:0]   b_texel;
	logic [AW-1:0] b_addr;
	logic [RW-1:0] b_row;
	prdr_flags_t   b_flags;

	assign cfg_ready = 1'b1;

	prdr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_word (pixel_word),
		.frame_start(frame_start),
		.q_push     (q_push),
		.q_full     (q_full),
		.q_texel    (f_texel),
		.q_addr     (f_addr),
		.q_row      (f_row),
		.q_flags    (f_flags)
	);

	assign q_din = {f_flags, f_row, f_addr, f_texel};

	prdr_fifo #(
		.WIDTH(QW),
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_data (q_dout)
	);

	assign {b_flags, b_row, b_addr, b_texel} = q_dout;

	prdr_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_texel       (b_texel),
		.q_addr        (b_addr),
		.q_row         (b_row),
		.q_flags       (b_flags),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.texel         (texel),
		.span_first_row(span_first_row),
		.span_rows     (span_rows),
		.last          (last)
	);

	a_span_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind |-> last)
		else $error("span result not marked last");

	a_texel_then_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !kind && !last |=> result_valid && kind)
		else $error("texel without last not followed by span");

	a_no_double_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && kind |=> !(result_valid && kind))
		else $error("two span results in a row");

endmodule

[sv/prdr_ram.sv]
`timescale 1ns / 1ps

module prdr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1048576
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/prdr_fifo.sv]
`timescale 1ns / 1ps

module prdr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PW'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

endmodule

[sv/prdr_front.sv]
`timescale 1ns / 1ps

module prdr_front
	import prdr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [31:0]           pixel_word,
	input  logic                  frame_start,
	output logic                  q_push,
	input  logic                  q_full,
	output logic [31:0]           q_texel,
	output logic [(MAX_WIDTH * MAX_HEIGHT > 1 ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] q_addr,
	output logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row,
	output prdr_flags_t           q_flags
);

	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;
	localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	logic [31:0]   red_mask_q;
	logic [31:0]   green_mask_q;
	logic [31:0]   blue_mask_q;
	prdr_shift_t   red_sh_q;
	prdr_shift_t   green_sh_q;
	prdr_shift_t   blue_sh_q;
	logic [CW-1:0] width_q;
	logic [HW-1:0] height_q;

	logic [XW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          vld_s1;
	logic [31:0]   pix_s1;
	logic [XW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	prdr_flags_t   flags_s1;

	logic          accept;
	logic [10:0]   cfg_size;
	logic [XW-1:0] c_cur;
	logic [RW-1:0] r_cur;
	logic [XW-1:0] col_c;
	logic [RW-1:0] row_c;
	logic          row_end_c;
	logic          frame_end_c;

	assign cfg_size = cfg_data[10:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= RED_MASK_RST;
			green_mask_q <= GREEN_MASK_RST;
			blue_mask_q  <= BLUE_MASK_RST;
			red_sh_q     <= shift_of(RED_MASK_RST, RED_POS);
			green_sh_q   <= shift_of(GREEN_MASK_RST, GREEN_POS);
			blue_sh_q    <= shift_of(BLUE_MASK_RST, BLUE_POS);
			width_q      <= CW'(W_RST);
			height_q     <= HW'(H_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RED_MASK: begin
					red_mask_q <= cfg_data;
					red_sh_q   <= shift_of(cfg_data, RED_POS);
				end
				CFG_GREEN_MASK: begin
					green_mask_q <= cfg_data;
					green_sh_q   <= shift_of(cfg_data, GREEN_POS);
				end
				CFG_BLUE_MASK: begin
					blue_mask_q <= cfg_data;
					blue_sh_q   <= shift_of(cfg_data, BLUE_POS);
				end
				CFG_LINE_WIDTH: begin
					if (cfg_size == '0) begin
						width_q <= CW'(1);
					end else if (32'(cfg_size) > 32'(MAX_WIDTH)) begin
						width_q <= CW'(MAX_WIDTH);
					end else begin
						width_q <= CW'(cfg_size);
					end
				end
				CFG_FRAME_HEIGHT: begin
					if (cfg_size == '0) begin
						height_q <= HW'(1);
					end else if (32'(cfg_size) > 32'(MAX_HEIGHT)) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= HW'(cfg_size);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// position of this pixel and end-of-row / end-of-frame classification
	always_comb begin
		c_cur = frame_start ? '0 : col_q;
		r_cur = frame_start ? '0 : row_q;
		if ((CW + 1)'(c_cur) < (CW + 1)'(width_q)) begin
			col_c = c_cur;
		end else begin
			col_c = XW'(width_q - CW'(1));
		end
		if ((HW + 1)'(r_cur) < (HW + 1)'(height_q)) begin
			row_c = r_cur;
		end else begin
			row_c = RW'(height_q - HW'(1));
		end
		row_end_c   = ((CW + 1)'(c_cur) + (CW + 1)'(1)) >= (CW + 1)'(width_q);
		frame_end_c = row_end_c &&
			(((HW + 1)'(r_cur) + (HW + 1)'(1)) >= (HW + 1)'(height_q));
	end

	assign pixel_stall = vld_s1 && q_full;
	assign accept      = pixel_valid && !pixel_stall;
	assign q_push      = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (frame_end_c) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end_c) begin
					col_q <= '0;
					row_q <= r_cur + RW'(1);
				end else begin
					col_q <= c_cur + XW'(1);
					row_q <= r_cur;
				end
			end else if (q_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1               <= pixel_word;
			col_s1               <= col_c;
			row_s1               <= row_c;
			flags_s1.frame_start <= frame_start;
			flags_s1.row_end     <= row_end_c;
			flags_s1.frame_end   <= frame_end_c;
		end
	end

	assign q_texel = place(pix_s1 & red_mask_q, red_sh_q)
		| place(pix_s1 & green_mask_q, green_sh_q)
		| place(pix_s1 & blue_mask_q, blue_sh_q)
		| ALPHA_BITS;
	assign q_addr  = AW'(row_s1) * AW'(MAX_WIDTH) + AW'(col_s1);
	assign q_row   = row_s1;
	assign q_flags = flags_s1;

endmodule

[sv/prdr_back.sv]
`timescale 1ns / 1ps

module prdr_back
	import prdr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  logic [31:0]   q_texel,
	input  logic [(MAX_WIDTH * MAX_HEIGHT > 1 ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] q_addr,
	input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row,
	input  prdr_flags_t   q_flags,
	output logic          result_valid,
	input  logic          result_stall,
	output logic          kind,
	output logic [31:0]   texel,
	output logic [9:0]    span_first_row,
	output logic [10:0]   span_rows,
	output logic          last
);

	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic          vld_s1;
	logic [31:0]   texel_s1;
	logic [AW-1:0] addr_s1;
	logic [RW-1:0] row_s1;
	prdr_flags_t   flags_s1;
	logic          fwd_hit_s1;
	logic [23:0]   fwd_data_s1;

	logic          frame_seen_q;
	logic          start_pend_q;
	logic          chg_pend_q;
	logic [RW-1:0] span_start_q;
	logic [RW-1:0] last_chg_q;

	logic          out_vld_q;
	logic          out_kind_q;
	logic [31:0]   out_texel_q;
	logic [9:0]    out_first_q;
	logic [10:0]   out_rows_q;
	logic          out_last_q;
	logic          span_vld_q;
	logic [9:0]    span_first_q;
	logic [10:0]   span_rows_q;

	logic [23:0]   rd_data;
	logic [23:0]   prev_rgb;
	logic          changed;
	logic          res_acc;
	logic          fire;

	logic          sp_n;
	logic          cp_n;
	logic [RW-1:0] ss_n;
	logic [RW-1:0] lc_n;
	logic          emit;
	logic [RW+10:0] ss_ext;
	logic [RW+10:0] lc_ext;
	logic [9:0]    emit_first;
	logic [10:0]   emit_rows;

	assign res_acc = out_vld_q && !result_stall;
	assign fire    = vld_s1 && (!out_vld_q || (res_acc && !span_vld_q));
	assign q_pop   = q_valid && (!vld_s1 || fire);

	prdr_ram #(
		.WIDTH(24),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (fire),
		.wr_addr(addr_s1),
		.wr_data(texel_s1[23:0]),
		.rd_en  (q_pop),
		.rd_addr(q_addr),
		.rd_data(rd_data)
	);

	assign prev_rgb = fwd_hit_s1 ? fwd_data_s1 : rd_data;
	assign changed  = !frame_seen_q || (prev_rgb != texel_s1[23:0]);

	// dirty span bookkeeping for the pixel in s1
	always_comb begin
		sp_n = flags_s1.frame_start ? 1'b0 : start_pend_q;
		cp_n = flags_s1.frame_start ? 1'b0 : chg_pend_q;
		ss_n = span_start_q;
		lc_n = last_chg_q;
		emit = 1'b0;
		if (changed) begin
			cp_n = 1'b1;
			lc_n = row_s1;
		end
		if (flags_s1.row_end && cp_n) begin
			if (!sp_n) begin
				sp_n = 1'b1;
				ss_n = row_s1;
			end
			if (lc_n != row_s1) begin
				emit = 1'b1;
				sp_n = 1'b0;
				cp_n = 1'b0;
			end
		end
		if (flags_s1.frame_end) begin
			if (cp_n) begin
				emit = 1'b1;
			end
			sp_n = 1'b0;
			cp_n = 1'b0;
		end
		ss_ext     = {11'b0, ss_n};
		lc_ext     = {11'b0, lc_n};
		emit_first = ss_ext[9:0];
		emit_rows  = lc_ext[10:0] - ss_ext[10:0] + 11'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			frame_seen_q <= 1'b0;
			start_pend_q <= 1'b0;
			chg_pend_q   <= 1'b0;
			span_start_q <= '0;
			last_chg_q   <= '0;
			out_vld_q    <= 1'b0;
			span_vld_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				start_pend_q <= sp_n;
				chg_pend_q   <= cp_n;
				span_start_q <= ss_n;
				last_chg_q   <= lc_n;
				if (flags_s1.frame_end) begin
					frame_seen_q <= 1'b1;
				end
			end
			if (res_acc && span_vld_q) begin
				span_vld_q <= 1'b0;
			end else if (fire) begin
				out_vld_q  <= 1'b1;
				span_vld_q <= emit;
			end else if (res_acc) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			texel_s1    <= q_texel;
			addr_s1     <= q_addr;
			row_s1      <= q_row;
			flags_s1    <= q_flags;
			fwd_hit_s1  <= fire && (addr_s1 == q_addr);
			fwd_data_s1 <= texel_s1[23:0];
		end
		if (res_acc && span_vld_q) begin
			out_kind_q  <= 1'b1;
			out_texel_q <= '0;
			out_first_q <= span_first_q;
			out_rows_q  <= span_rows_q;
			out_last_q  <= 1'b1;
		end else if (fire) begin
			out_kind_q   <= 1'b0;
			out_texel_q  <= texel_s1;
			out_first_q  <= '0;
			out_rows_q   <= '0;
			out_last_q   <= !emit;
			span_first_q <= emit_first;
			span_rows_q  <= emit_rows;
		end
	end

	assign result_valid   = out_vld_q;
	assign kind           = out_kind_q;
	assign texel          = out_texel_q;
	assign span_first_row = out_first_q;
	assign span_rows      = out_rows_q;
	assign last           = out_last_q;

endmodule
